### rtl/core/assert_macros.svh
// assertion macros shared by the push buffer decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define PBD_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition in one cycle implies expression in the next
`define PBD_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) else $error(msg);

`endif

### rtl/core/pbd_pkg.sv
// shared types and constants of the push buffer command decoder
package pbd_pkg;

  // word pattern masks
  localparam logic [31:0] HDR_MASK      = 32'hE000_0003;
  localparam logic [31:0] OLD_JUMP_PAT  = 32'h2000_0000;
  localparam logic [31:0] OLD_JUMP_ADDR = 32'h1FFF_FFFF;
  localparam logic [31:0] RETURN_WORD   = 32'h0002_0000;
  localparam logic [31:0] MTHD_MASK     = 32'hE003_0003;
  localparam logic [31:0] NONINC_PAT    = 32'h4000_0000;
  localparam logic [31:0] ADDR_MASK     = 32'hFFFF_FFFC;
  localparam logic [31:0] GET_STEP      = 32'd4;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_BUFFER_LIMIT      = 2'd0;
  localparam logic [1:0] CFG_PUSHER_ACCESS     = 2'd1;
  localparam logic [1:0] CFG_CACHE_PUSH_ACCESS = 2'd2;

  typedef enum logic [1:0] {
    OP_WORD     = 2'd0,
    OP_LOAD_GET = 2'd1,
    OP_RESUME   = 2'd2,
    OP_IRQ_ACK  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CMD_OLD_JUMP,
    CMD_JUMP,
    CMD_CALL,
    CMD_RETURN,
    CMD_HEADER,
    CMD_RESERVED
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_DATA    = 3'd1,
    KIND_CMD     = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_IGNORED = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_PROTECTION = 3'd1,
    ERR_CALL       = 3'd2,
    ERR_RETURN     = 3'd3,
    ERR_RESERVED   = 3'd4
  } err_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t         op;
    cmd_t        cmd;
    logic        noninc;
    logic [31:0] data;
  } item_t;

endpackage

### rtl/core/pbd_front.sv
// front end: classifies each incoming transfer before it is queued
module pbd_front (
  input  logic [1:0]     in_opcode,
  input  logic [31:0]    in_word,
  input  logic [31:0]    in_get_value,
  output pbd_pkg::item_t item
);
  import pbd_pkg::*;

  logic [31:0] mthd;
  cmd_t        cmd;

  assign mthd = in_word & MTHD_MASK;

  // command class in the priority order of the decoder
  always_comb begin
    if ((in_word & HDR_MASK) == OLD_JUMP_PAT) begin
      cmd = CMD_OLD_JUMP;
    end else if (in_word[1:0] == 2'd1) begin
      cmd = CMD_JUMP;
    end else if (in_word[1:0] == 2'd2) begin
      cmd = CMD_CALL;
    end else if (in_word == RETURN_WORD) begin
      cmd = CMD_RETURN;
    end else if (mthd == 32'd0 || mthd == NONINC_PAT) begin
      cmd = CMD_HEADER;
    end else begin
      cmd = CMD_RESERVED;
    end
  end

  // a pointer load carries the aligned get value, all else the word
  always_comb begin
    item.op     = op_t'(in_opcode);
    item.cmd    = cmd;
    item.noninc = (mthd == NONINC_PAT);
    item.data   = (item.op == OP_LOAD_GET) ? (in_get_value & ADDR_MASK) : in_word;
  end

endmodule

### rtl/core/pbd_queue.sv
// short queue between the classifying front and the executing back
module pbd_queue #(
  parameter int DEPTH = pbd_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  pbd_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pbd_pkg::item_t pop_item
);
  import pbd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push, pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slot_r[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

`include "assert_macros.svh"

  `PBD_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue occupancy above depth")
  `PBD_ASSERT_NEXT(a_count_grow, push && !pop, count_r == $past(count_r) + 1'b1, "push lost")

endmodule

### rtl/core/pbd_back.sv
// back end: decoder state, command execution and result register
module pbd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_take,
  input  pbd_pkg::item_t item,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [31:0]    cfg_wdata,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [95:0]    out_tdata,
  output logic [2:0]     out_tuser
);
  import pbd_pkg::*;

  // configuration
  logic [31:0] limit_r;
  logic        pusher_en_r;
  logic        cache_en_r;

  // decoder state
  logic [31:0] get_r, get_nxt;
  logic        sub_r, sub_nxt;
  logic [31:0] ret_r, ret_nxt;
  logic        type_r, type_nxt;
  logic [10:0] mthd_r, mthd_nxt;
  logic [2:0]  subch_r, subch_nxt;
  logic [10:0] count_r, count_nxt;
  logic        halted_r, halted_nxt;
  err_t        fault_r, fault_nxt;
  logic        irq_r, irq_nxt;

  // result
  kind_t       kind;
  logic        e_type;
  logic [10:0] e_mthd;
  logic [2:0]  e_sub;
  logic [31:0] e_data;
  logic [31:0] get_inc;
  logic        out_valid_r;
  logic [95:0] out_data_r;
  kind_t       out_kind_r;

  assign item_take  = item_valid && (!out_valid_r || out_tready);
  assign get_inc    = get_r + GET_STEP;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // execution of one item
  always_comb begin
    get_nxt    = get_r;
    sub_nxt    = sub_r;
    ret_nxt    = ret_r;
    type_nxt   = type_r;
    mthd_nxt   = mthd_r;
    subch_nxt  = subch_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    fault_nxt  = fault_r;
    irq_nxt    = irq_r;
    kind       = KIND_NONE;
    e_type     = 1'b0;
    e_mthd     = '0;
    e_sub      = '0;
    e_data     = '0;
    case (item.op)
      OP_LOAD_GET: get_nxt = item.data;
      OP_RESUME: begin
        halted_nxt = 1'b0;
        fault_nxt  = ERR_NONE;
      end
      OP_IRQ_ACK: irq_nxt = 1'b0;
      default: begin
        if (!pusher_en_r || !cache_en_r || halted_r) begin
          kind = KIND_IGNORED;
        end else if (get_r >= limit_r) begin
          kind       = KIND_ERROR;
          fault_nxt  = ERR_PROTECTION;
          halted_nxt = 1'b1;
          irq_nxt    = 1'b1;
        end else if (count_r != '0) begin
          // parameter word of the current method
          get_nxt   = get_inc;
          kind      = KIND_DATA;
          e_type    = type_r;
          e_mthd    = mthd_r;
          e_sub     = subch_r;
          e_data    = item.data;
          mthd_nxt  = type_r ? mthd_r : mthd_r + 1'b1;
          count_nxt = count_r - 1'b1;
        end else begin
          get_nxt = get_inc;
          kind    = KIND_CMD;
          case (item.cmd)
            CMD_OLD_JUMP: get_nxt = item.data & OLD_JUMP_ADDR;
            CMD_JUMP:     get_nxt = item.data & ADDR_MASK;
            CMD_CALL: begin
              if (sub_r) begin
                kind       = KIND_ERROR;
                fault_nxt  = ERR_CALL;
                halted_nxt = 1'b1;
                irq_nxt    = 1'b1;
              end else begin
                ret_nxt = get_inc;
                sub_nxt = 1'b1;
                get_nxt = item.data & ADDR_MASK;
              end
            end
            CMD_RETURN: begin
              if (!sub_r) begin
                kind       = KIND_ERROR;
                fault_nxt  = ERR_RETURN;
                halted_nxt = 1'b1;
                irq_nxt    = 1'b1;
              end else begin
                get_nxt = ret_r & ADDR_MASK;
                sub_nxt = 1'b0;
              end
            end
            CMD_HEADER: begin
              type_nxt  = item.noninc;
              mthd_nxt  = item.data[12:2];
              subch_nxt = item.data[15:13];
              count_nxt = item.data[28:18];
            end
            default: begin
              kind       = KIND_ERROR;
              fault_nxt  = ERR_RESERVED;
              halted_nxt = 1'b1;
              irq_nxt    = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= '0;
      pusher_en_r <= 1'b0;
      cache_en_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUFFER_LIMIT:      limit_r     <= cfg_wdata;
        CFG_PUSHER_ACCESS:     pusher_en_r <= cfg_wdata[0];
        CFG_CACHE_PUSH_ACCESS: cache_en_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // decoder state update on each taken item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      get_r    <= '0;
      sub_r    <= 1'b0;
      ret_r    <= '0;
      type_r   <= 1'b0;
      mthd_r   <= '0;
      subch_r  <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
      fault_r  <= ERR_NONE;
      irq_r    <= 1'b0;
    end else if (item_take) begin
      get_r    <= get_nxt;
      sub_r    <= sub_nxt;
      ret_r    <= ret_nxt;
      type_r   <= type_nxt;
      mthd_r   <= mthd_nxt;
      subch_r  <= subch_nxt;
      count_r  <= count_nxt;
      halted_r <= halted_nxt;
      fault_r  <= fault_nxt;
      irq_r    <= irq_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (item_take) begin
      out_kind_r <= kind;
      out_data_r <= {1'b0, count_nxt, irq_nxt, halted_nxt, fault_nxt, get_nxt,
                     e_data, e_sub, e_mthd, e_type};
    end
  end

`include "assert_macros.svh"

  `PBD_ASSERT(a_halt_code, (halted_r == 1'b0) == (fault_r == ERR_NONE), "halt and code disagree")
  `PBD_ASSERT_NEXT(a_error_halts, item_take && kind == KIND_ERROR, halted_r && irq_r, "error did not halt")

endmodule

### rtl/core/gpu_pushbuffer_command_decoder_top.sv
// top level of the push buffer command decoder
// The decoder takes one transfer per cycle on the in_ channel while in_tready is high and
// returns exactly one result transfer for each. The front classifies the word in the accept
// cycle, a two-entry queue decouples it from the back, and the back executes against the get
// pointer, call slot and method header and holds the result in the output register. While that
// result waits, the queue still takes up to two more items. Once the queue is full, in_tready
// drops and returns in the cycle after out_tready rises. The back can take a new item while its
// previous result leaves; stalls on out_tready back up through the queue to in_tready.
// Configuration is written through cfg_we, cfg_index and cfg_wdata; the user must write it only
// while no item is in flight, as the block itself does not enforce this.
module gpu_pushbuffer_command_decoder_top #(
  parameter int QUEUE_DEPTH = pbd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // word, get_value
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // method_type, method_index, subchannel, param_data,
                                  // next_get, error_code, suspended, irq_pending, words_left
  output logic [2:0]  out_tuser,  // result_kind
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import pbd_pkg::*;

  item_t front_item;
  item_t back_item;
  logic  back_valid;
  logic  back_take;

  // classify
  pbd_front u_front (
    .in_opcode    (in_tuser),
    .in_word      (in_tdata[31:0]),
    .in_get_value (in_tdata[63:32]),
    .item         (front_item)
  );

  // decouple
  pbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_take),
    .pop_item   (back_item)
  );

  // execute
  pbd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (back_valid),
    .item_take  (back_take),
    .item       (back_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
